>>> rtl/assert_macros.svh
// Assertion macros shared by the quaternion to rotation matrix RTL.
// No dependencies; each file that checks its own logic includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define QRM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever ante holds, cons must hold at the same edge.
`define QRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/qrm_pkg.sv
// Shared widths, types and index codes for the quaternion to rotation matrix pipeline.
// No dependencies; imported by every module of the block.
package qrm_pkg;

  localparam int FRAC_BITS = 14;             // fraction bits of Q-format fields
  localparam int NELEM     = 9;              // matrix elements per item
  localparam int NPROD     = 10;             // distinct component products
  localparam int CW        = 16;             // component / element width
  localparam int PRW       = 2 * CW;         // product width
  localparam int PW        = PRW + 2;        // signed numerator width
  localparam int DW        = PRW + 2;        // divider remainder / denominator width
  localparam int QW        = FRAC_BITS + 1;  // quotient bits, one per divider stage
  localparam int RW        = QW + 1;         // rounded quotient width
  localparam int EW        = ((RW > CW) ? RW : CW) + 1;
  localparam int IN_W      = 4 * CW;
  localparam int OUT_W     = NELEM * CW;

  // product indexes
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_WW = 3;
  localparam int P_XY = 4;
  localparam int P_XZ = 5;
  localparam int P_YZ = 6;
  localparam int P_WX = 7;
  localparam int P_WY = 8;
  localparam int P_WZ = 9;

  // element indexes, row by row
  localparam int E_R0C0 = 0;
  localparam int E_R0C1 = 1;
  localparam int E_R0C2 = 2;
  localparam int E_R1C0 = 3;
  localparam int E_R1C1 = 4;
  localparam int E_R1C2 = 5;
  localparam int E_R2C0 = 6;
  localparam int E_R2C1 = 7;
  localparam int E_R2C2 = 8;

  typedef logic signed [CW-1:0]  comp_t;
  typedef logic signed [PRW-1:0] prod_t;
  typedef logic signed [PW-1:0]  term_t;
  typedef logic [DW-1:0]         dword_t;
  typedef logic [QW-1:0]         quo_t;
  typedef logic [RW-1:0]         qrnd_t;

  localparam qrnd_t ONE_Q = qrnd_t'(1) << FRAC_BITS;

  // control travelling alongside the data of one item
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [NELEM-1:0] neg;
  } side_t;

  typedef struct packed {
    dword_t rem;
    quo_t   quo;
  } lane_t;

endpackage

>>> rtl/quaternion_to_rotation_matrix_top.sv
// Quaternion (Q2.14) to 3x3 rotation matrix, fully pipelined.
// Stages: product, two term stages, one divider stage per quotient bit, round,
// output register. One item per cycle while no result is held at the output.
// A result held by out_tready low stalls the whole pipeline; nothing is dropped.
// Synchronous active-low reset clears only the side control (valid, zero and sign
// bits). Depends on qrm_pkg, qrm_mult, qrm_terms, qrm_div, qrm_round and assert_macros.svh.
`include "assert_macros.svh"
module quaternion_to_rotation_matrix_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [qrm_pkg::IN_W-1:0]   in_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2, e_r2c0, e_r2c1, e_r2c2
  output logic [qrm_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tuser   // zero_length
);
  import qrm_pkg::*;

  logic   adv;
  logic   valid_m;
  prod_t  prod   [NPROD];
  side_t  side_t3, side_dv, side_out;
  dword_t den_t3, den_dv;
  dword_t mag    [NELEM];
  lane_t  lane   [NELEM];
  comp_t  elem   [NELEM];

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  qrm_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .qx       (comp_t'(in_tdata[CW-1:0])),
    .qy       (comp_t'(in_tdata[2*CW-1:CW])),
    .qz       (comp_t'(in_tdata[3*CW-1:2*CW])),
    .qw       (comp_t'(in_tdata[4*CW-1:3*CW])),
    .valid_o  (valid_m),
    .prod_o   (prod)
  );

  qrm_terms u_terms (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (valid_m),
    .prod_i  (prod),
    .side_o  (side_t3),
    .den_o   (den_t3),
    .mag_o   (mag)
  );

  qrm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (side_t3),
    .den_i  (den_t3),
    .mag_i  (mag),
    .side_o (side_dv),
    .den_o  (den_dv),
    .lane_o (lane)
  );

  qrm_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (side_dv),
    .den_i  (den_dv),
    .lane_i (lane),
    .side_o (side_out),
    .elem_o (elem)
  );

  always_comb begin
    for (int e = 0; e < NELEM; e++) begin
      out_tdata[e*CW +: CW] = elem[e];
    end
  end

  assign out_tvalid = side_out.valid;
  assign out_tuser  = side_out.zero;

  // zero quaternion must come out as an all-zero matrix
  `QRM_ASSERT_IMPL(a_top_zero_data, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0, "zero flag with non-zero matrix")
  // an empty output register must never hold back the input
  `QRM_ASSERT_IMPL(a_top_ready_free, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")

endmodule

>>> rtl/qrm_mult.sv
// Stage 1: the ten component products of the quaternion, registered.
// Depends on qrm_pkg.
module qrm_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  qrm_pkg::comp_t qx,
  input  qrm_pkg::comp_t qy,
  input  qrm_pkg::comp_t qz,
  input  qrm_pkg::comp_t qw,
  output logic           valid_o,
  output qrm_pkg::prod_t prod_o [qrm_pkg::NPROD]
);
  import qrm_pkg::*;

  prod_t prod_nxt [NPROD];
  prod_t prod_r   [NPROD];
  logic  valid_r;

  always_comb begin
    prod_nxt[P_XX] = qx * qx;
    prod_nxt[P_YY] = qy * qy;
    prod_nxt[P_ZZ] = qz * qz;
    prod_nxt[P_WW] = qw * qw;
    prod_nxt[P_XY] = qx * qy;
    prod_nxt[P_XZ] = qx * qz;
    prod_nxt[P_YZ] = qy * qz;
    prod_nxt[P_WX] = qw * qx;
    prod_nxt[P_WY] = qw * qy;
    prod_nxt[P_WZ] = qw * qz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign valid_o = valid_r;
  assign prod_o  = prod_r;

endmodule

>>> rtl/qrm_terms.sv
// Stages 2 and 3: squared length and the nine element numerators, then
// their magnitudes, signs and the zero-length flag. Depends on qrm_pkg.
module qrm_terms (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            valid_i,
  input  qrm_pkg::prod_t  prod_i [qrm_pkg::NPROD],
  output qrm_pkg::side_t  side_o,
  output qrm_pkg::dword_t den_o,
  output qrm_pkg::dword_t mag_o [qrm_pkg::NELEM]
);
  import qrm_pkg::*;

  term_t  xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  term_t  p_nxt [NELEM];
  term_t  p_r   [NELEM];
  dword_t den_b_nxt, den_b_r;
  logic   valid_b_r;

  side_t  side_c_nxt, side_c_r;
  dword_t mag_nxt [NELEM];
  dword_t mag_r   [NELEM];
  dword_t den_c_r;

  always_comb begin
    xx = PW'(prod_i[P_XX]);
    yy = PW'(prod_i[P_YY]);
    zz = PW'(prod_i[P_ZZ]);
    ww = PW'(prod_i[P_WW]);
    xy = PW'(prod_i[P_XY]);
    xz = PW'(prod_i[P_XZ]);
    yz = PW'(prod_i[P_YZ]);
    wx = PW'(prod_i[P_WX]);
    wy = PW'(prod_i[P_WY]);
    wz = PW'(prod_i[P_WZ]);

    den_b_nxt = $unsigned(xx + yy + zz + ww);

    p_nxt[E_R0C0] = xx + ww - yy - zz;
    p_nxt[E_R0C1] = (xy + wz) <<< 1;
    p_nxt[E_R0C2] = (xz - wy) <<< 1;
    p_nxt[E_R1C0] = (xy - wz) <<< 1;
    p_nxt[E_R1C1] = ww + yy - xx - zz;
    p_nxt[E_R1C2] = (yz + wx) <<< 1;
    p_nxt[E_R2C0] = (xz + wy) <<< 1;
    p_nxt[E_R2C1] = (yz - wx) <<< 1;
    p_nxt[E_R2C2] = ww + zz - xx - yy;
  end

  always_comb begin
    side_c_nxt.valid = valid_b_r;
    side_c_nxt.zero  = (den_b_r == '0);
    for (int e = 0; e < NELEM; e++) begin
      side_c_nxt.neg[e] = p_r[e][PW-1];
      mag_nxt[e] = p_r[e][PW-1] ? $unsigned(-p_r[e]) : $unsigned(p_r[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
      side_c_r  <= '0;
    end else if (adv) begin
      valid_b_r <= valid_i;
      side_c_r  <= side_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r     <= p_nxt;
      den_b_r <= den_b_nxt;
      mag_r   <= mag_nxt;
      den_c_r <= den_b_r;
    end
  end

  assign side_o = side_c_r;
  assign den_o  = den_c_r;
  assign mag_o  = mag_r;

endmodule

>>> rtl/qrm_div.sv
// Pipelined restoring divider, one quotient bit per stage, nine lanes sharing
// one denominator. Gives floor(mag * 2^FRAC_BITS / den) and twice the remainder.
// Depends on qrm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qrm_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  qrm_pkg::side_t  side_i,
  input  qrm_pkg::dword_t den_i,
  input  qrm_pkg::dword_t mag_i [qrm_pkg::NELEM],
  output qrm_pkg::side_t  side_o,
  output qrm_pkg::dword_t den_o,
  output qrm_pkg::lane_t  lane_o [qrm_pkg::NELEM]
);
  import qrm_pkg::*;

  lane_t  src    [QW][NELEM];
  dword_t dsrc   [QW];
  side_t  ssrc   [QW];
  lane_t  ln_nxt [QW][NELEM];
  lane_t  ln_r   [QW][NELEM];
  dword_t den_r  [QW];
  side_t  side_r [QW];
  logic [NELEM-1:0] rem_ok;

  always_comb begin
    for (int e = 0; e < NELEM; e++) begin
      src[0][e].rem = mag_i[e];
      src[0][e].quo = '0;
    end
    dsrc[0] = den_i;
    ssrc[0] = side_i;
    for (int s = 1; s < QW; s++) begin
      for (int e = 0; e < NELEM; e++) begin
        src[s][e] = ln_r[s-1][e];
      end
      dsrc[s] = den_r[s-1];
      ssrc[s] = side_r[s-1];
    end
  end

  // one compare and subtract per lane per stage; remainder doubled for the next bit
  always_comb begin
    logic   take;
    dword_t rn;
    take = 1'b0;
    rn   = '0;
    for (int s = 0; s < QW; s++) begin
      for (int e = 0; e < NELEM; e++) begin
        take = (src[s][e].rem >= dsrc[s]);
        rn   = take ? (src[s][e].rem - dsrc[s]) : src[s][e].rem;
        ln_nxt[s][e].rem = {rn[DW-2:0], 1'b0};
        ln_nxt[s][e].quo = {src[s][e].quo[QW-2:0], take};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QW; s++) begin
        side_r[s] <= '0;
      end
    end else if (adv) begin
      side_r <= ssrc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ln_r  <= ln_nxt;
      den_r <= dsrc;
    end
  end

  assign side_o = side_r[QW-1];
  assign den_o  = den_r[QW-1];
  assign lane_o = ln_r[QW-1];

  always_comb begin
    for (int e = 0; e < NELEM; e++) begin
      rem_ok[e] = (ln_r[QW-1][e].rem < {den_r[QW-1][DW-2:0], 1'b0});
    end
  end

  // doubled remainder stays below twice the denominator on every real item
  `QRM_ASSERT_IMPL(a_div_rem_bound, clk, rst_n, side_r[QW-1].valid && !side_r[QW-1].zero, &rem_ok, "divider remainder out of range")

endmodule

>>> rtl/qrm_round.sv
// Final two stages: round half away from zero, then clamp, restore sign,
// force zero for a zero quaternion. Depends on qrm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qrm_round (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  qrm_pkg::side_t  side_i,
  input  qrm_pkg::dword_t den_i,
  input  qrm_pkg::lane_t  lane_i [qrm_pkg::NELEM],
  output qrm_pkg::side_t  side_o,
  output qrm_pkg::comp_t  elem_o [qrm_pkg::NELEM]
);
  import qrm_pkg::*;

  qrnd_t qr_nxt [NELEM];
  qrnd_t qr_r   [NELEM];
  side_t side1_r, side2_r;
  comp_t elem_nxt [NELEM];
  comp_t elem_r   [NELEM];
  logic [NELEM-1:0] qr_ok;

  // lane rem is already twice the remainder, so this is the half-way test
  always_comb begin
    for (int e = 0; e < NELEM; e++) begin
      qr_nxt[e] = RW'(lane_i[e].quo) + RW'(lane_i[e].rem >= den_i);
    end
  end

  always_comb begin
    qrnd_t          qc;
    logic [EW-1:0]  ext;
    qc  = '0;
    ext = '0;
    for (int e = 0; e < NELEM; e++) begin
      qc  = (qr_r[e] > ONE_Q) ? ONE_Q : qr_r[e];
      ext = EW'(qc);
      if (side1_r.neg[e]) begin
        ext = -ext;
      end
      elem_nxt[e] = side1_r.zero ? '0 : $signed(ext[CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
      side2_r <= '0;
    end else if (adv) begin
      side1_r <= side_i;
      side2_r <= side1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qr_r   <= qr_nxt;
      elem_r <= elem_nxt;
    end
  end

  assign side_o = side2_r;
  assign elem_o = elem_r;

  always_comb begin
    for (int e = 0; e < NELEM; e++) begin
      qr_ok[e] = (qr_r[e] <= ONE_Q);
    end
  end

  // a unit-scaled element can never exceed 1.0 before the guard clamp
  `QRM_ASSERT_IMPL(a_round_in_range, clk, rst_n, side1_r.valid && !side1_r.zero, &qr_ok, "rounded element above one")

endmodule

>>> tb/sv/qrm_rotation_checker.sv
// Scoreboard for the quaternion to rotation matrix block: predicts each matrix
// from the accepted quaternion and compares it with the result stream in order.
// Depends on qrm_pkg for widths and element indexes.
module qrm_rotation_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [qrm_pkg::IN_W-1:0]  in_tdata,   // quat_x, quat_y, quat_z, quat_w
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  // e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2, e_r2c0, e_r2c1, e_r2c2
  input  logic [qrm_pkg::OUT_W-1:0] out_tdata,
  input  logic                      out_tuser,  // zero_length
  output int                        fail_count,
  output int                        pending
);
  import qrm_pkg::*;

  typedef struct packed {
    logic             zero;
    logic [OUT_W-1:0] elems;
  } rot_matrix_t;

  rot_matrix_t matrices_due[$];
  int          errs  = 0;
  int          depth = 0;

  string elem_name [NELEM] = '{"e_r0c0", "e_r0c1", "e_r0c2", "e_r1c0", "e_r1c1",
                               "e_r1c2", "e_r2c0", "e_r2c1", "e_r2c2"};

  assign fail_count = errs;
  assign pending    = depth;

  // S*p/n rounded to nearest, ties away from zero, clamped to +-1.0
  function automatic logic [CW-1:0] scaled_ratio(input longint p, input longint n);
    longint s;
    longint mag;
    longint num;
    longint q;
    longint r;
    s   = longint'(1) <<< FRAC_BITS;
    mag = (p < 0) ? -p : p;
    num = mag * s;
    q   = num / n;
    r   = num - q * n;
    if (r >= n - r) q = q + 1;
    if (q > s) q = s;
    if (p < 0) q = -q;
    return q[CW-1:0];
  endfunction

  function automatic rot_matrix_t rotation_of(input logic [IN_W-1:0] quat);
    longint      x, y, z, w;
    longint      xx, yy, zz, ww, n;
    longint      poly [NELEM];
    rot_matrix_t m;
    x  = longint'(comp_t'(quat[0*CW +: CW]));
    y  = longint'(comp_t'(quat[1*CW +: CW]));
    z  = longint'(comp_t'(quat[2*CW +: CW]));
    w  = longint'(comp_t'(quat[3*CW +: CW]));
    xx = x * x;
    yy = y * y;
    zz = z * z;
    ww = w * w;
    n  = xx + yy + zz + ww;
    m.zero  = (n == 0);
    m.elems = '0;
    if (n != 0) begin
      poly[E_R0C0] = xx + ww - yy - zz;
      poly[E_R0C1] = 2 * (x * y + w * z);
      poly[E_R0C2] = 2 * (x * z - w * y);
      poly[E_R1C0] = 2 * (x * y - w * z);
      poly[E_R1C1] = ww + yy - xx - zz;
      poly[E_R1C2] = 2 * (y * z + w * x);
      poly[E_R2C0] = 2 * (x * z + w * y);
      poly[E_R2C1] = 2 * (y * z - w * x);
      poly[E_R2C2] = ww + zz - xx - yy;
      for (int k = 0; k < NELEM; k++)
        m.elems[k*CW +: CW] = scaled_ratio(poly[k], n);
    end
    return m;
  endfunction

  always @(posedge clk) begin : watch
    rot_matrix_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        matrices_due.push_back(rotation_of(in_tdata));
      if (out_tvalid && out_tready) begin
        if (matrices_due.size() == 0) begin
          errs = errs + 1;
          $display("%0t: unexpected item, expected none, actual tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = matrices_due.pop_front();
          for (int k = 0; k < NELEM; k++) begin
            if (out_tdata[k*CW +: CW] !== want.elems[k*CW +: CW]) begin
              errs = errs + 1;
              $display("%0t: %s expected %0d actual %0d", $time, elem_name[k],
                       $signed(want.elems[k*CW +: CW]), $signed(out_tdata[k*CW +: CW]));
            end
          end
          if (out_tuser !== want.zero) begin
            errs = errs + 1;
            $display("%0t: zero_length expected %b actual %b", $time, want.zero, out_tuser);
          end
        end
      end
      depth = matrices_due.size();
    end
  end

endmodule

>>> tb/sv/tb_quaternion_to_rotation_matrix_top.sv
// Top of the quaternion to rotation matrix testbench: clock, reset, quaternion
// stimulus and result back-pressure. Depends on qrm_pkg, the block and qrm_rotation_checker.
module tb_quaternion_to_rotation_matrix_top;
  import qrm_pkg::*;

  localparam int RANDOM_ITEMS = 1880;
  localparam int HOLD_FROM    = 600;   // sink cycles before the long hold-off
  localparam int HOLD_LEN     = 160;
  localparam int FREE_FROM    = 1500;  // sink always ready in this window
  localparam int FREE_TO      = 2300;
  localparam int DRAIN_CYCLES = 40;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  int               fail_count;
  int               pending;
  bit               gaps_on    = 1'b1;

  comp_t corner [7] = '{-16'sd32768, -16'sd16384, -16'sd1, 16'sd0, 16'sd1,
                        16'sd16384, 16'sd32767};

  always #4 clk = ~clk;

  quaternion_to_rotation_matrix_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  qrm_rotation_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one quaternion, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_quat(input comp_t x, input comp_t y, input comp_t z, input comp_t w);
    while (gaps_on && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sink: random stalls, one long hold-off so the pipeline fills, one stall-free window
  initial begin : sink_ctrl
    int unsigned cyc;
    cyc = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc = cyc + 1;
      if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_LEN)
        out_tready <= 1'b0;
      else if (cyc >= FREE_FROM && cyc < FREE_TO)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99) >= 37);
    end
  end

  initial begin : watchdog
    #1600000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    comp_t q [4];
    int    pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero quaternion, axis-aligned, extremes and mixed signs
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd1);
    send_quat(16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_quat(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
    send_quat(16'sd1, 16'sd2, 16'sd3, 16'sd4);
    send_quat(-16'sd1, 16'sd32767, 16'sd0, -16'sd32768);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 1000 && i < 1300);
      pick = $urandom_range(99);
      for (int c = 0; c < 4; c++) begin
        if (pick < 40)
          q[c] = comp_t'($urandom_range(16'hFFFF));
        else if (pick < 80)
          q[c] = comp_t'(int'($urandom_range(32768)) - 16384);
        else if (pick < 90)
          q[c] = comp_t'(int'($urandom_range(8)) - 4);
        else if (pick < 95)
          q[c] = '0;
        else
          q[c] = corner[$urandom_range(6)];
      end
      // zero quaternion, or one lone component at a corner value
      if (pick >= 90 && pick < 95 && $urandom_range(1))
        q[$urandom_range(3)] = corner[$urandom_range(6)];
      send_quat(q[0], q[1], q[2], q[3]);
    end
    in_tvalid <= 1'b0;

    // wait so the checker has queued the last item before pending is read
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
